// ===== rtl/core/qai_pkg.sv =====
// Package: widths, types and helpers for the quaternion attitude integrator.
`default_nettype none
package qai_pkg;
	localparam int FRAC_BITS_DEF = 14;
	localparam int Q_W = 16;
	localparam int DQ_SHIFT = 27;
	localparam int NORM_GUARD = 14;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_INTEGRATE = 1'b1;

	typedef logic signed [Q_W-1:0] comp_t;

	typedef struct packed {
		logic signed [34:0] p;
		logic signed [15:0] q;
	} lane_in_t;

	function automatic comp_t sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		if (v < -48'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/qai_lane.sv =====
// One lane: scales a product component by the time step, rounds, adds and saturates.
`default_nettype none
module qai_lane
	import qai_pkg::*;
(
	input wire logic clk,
	input wire logic start,
	input wire lane_in_t din,
	input wire logic [15:0] dt,
	output comp_t s
);
	logic signed [51:0] prod_s1;
	logic [51:0] mag;
	logic [51:0] rnd;
	logic signed [47:0] dq;
	comp_t q_s1;
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= din.p * $signed({1'b0, dt});
			q_s1 <= din.q;
		end
	end
	always_comb begin
		mag = prod_s1[51] ? 52'(-prod_s1) : 52'(prod_s1);
		rnd = (mag + (52'd1 << (DQ_SHIFT - 1))) >> DQ_SHIFT;
		dq = prod_s1[51] ? -$signed(rnd[47:0]) : $signed(rnd[47:0]);
		s = sat16(48'(q_s1) + dq);
	end
endmodule
`default_nettype wire

// ===== rtl/core/qai_norm.sv =====
// Merge stage: sum of squares, serial square root and serial divides per component.
`default_nettype none
module qai_norm
	import qai_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire comp_t s0,
	input wire comp_t s1,
	input wire comp_t s2,
	input wire comp_t s3,
	output logic done,
	output logic zero,
	output comp_t r0,
	output comp_t r1,
	output comp_t r2,
	output comp_t r3
);
	localparam int NS = FRAC_BITS + NORM_GUARD;
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001, ST_SQRT = 4'b0010, ST_DIV = 4'b0100, ST_DONE = 4'b1000
	} st_t;
	st_t st_q;
	comp_t s_q [4];
	logic [63:0] rem_q, res_q, bit_q;
	logic [31:0] root_q;
	logic [1:0] idx_q;
	logic [6:0] cnt_q;
	logic [127:0] num_q;
	logic [63:0] dr_q;
	logic [63:0] quo_q;
	comp_t r_q [4];
	logic [33:0] n2;
	logic [63:0] rmag;
	logic signed [47:0] sres;
	comp_t cur;
	always_comb begin
		n2 = 34'(s0 * s0) + 34'(s1 * s1) + 34'(s2 * s2) + 34'(s3 * s3);
		cur = s_q[idx_q];
		rmag = (quo_q > 64'h7fffffff) ? 64'h7fffffff : quo_q;
		sres = cur[15] ? -$signed(48'(rmag)) : $signed(48'(rmag));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						s_q[0] <= s0; s_q[1] <= s1; s_q[2] <= s2; s_q[3] <= s3;
						if (n2 == 0) begin
							zero <= 1'b1;
							st_q <= ST_DONE;
						end else begin
							zero <= 1'b0;
							rem_q <= {2'd0, n2, 28'd0};
							res_q <= '0;
							bit_q <= 64'd1 << 62;
							st_q <= ST_SQRT;
						end
					end
				end
				ST_SQRT: begin
					if (bit_q == 0) begin
						root_q <= res_q[31:0];
						idx_q <= '0;
						cnt_q <= '0;
						dr_q <= '0;
						quo_q <= '0;
						num_q <= (128'($unsigned(s_q[0][15] ? 16'(-s_q[0]) : s_q[0])) << NS)
							+ 128'(res_q[31:1]);
						st_q <= ST_DIV;
					end else begin
						if (rem_q >= res_q + bit_q) begin
							rem_q <= rem_q - (res_q + bit_q);
							res_q <= (res_q >> 1) + bit_q;
						end else res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
					end
				end
				ST_DIV: begin
					if (cnt_q == 7'd64) begin
						r_q[idx_q] <= sat16(sres);
						idx_q <= idx_q + 2'd1;
						cnt_q <= '0;
						dr_q <= '0;
						quo_q <= '0;
						num_q <= (128'($unsigned(s_q[idx_q+2'd1][15] ? 16'(-s_q[idx_q+2'd1])
							: s_q[idx_q+2'd1])) << NS) + 128'(root_q[31:1]);
						if (idx_q == 2'd3) st_q <= ST_DONE;
					end else begin
						if ({dr_q[62:0], num_q[63]} >= 64'(root_q)) begin
							dr_q <= {dr_q[62:0], num_q[63]} - 64'(root_q);
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							dr_q <= {dr_q[62:0], num_q[63]};
							quo_q <= {quo_q[62:0], 1'b0};
						end
						num_q <= num_q << 1;
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_DONE: begin
					done <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
	assign r0 = r_q[0];
	assign r1 = r_q[1];
	assign r2 = r_q[2];
	assign r3 = r_q[3];
endmodule
`default_nettype wire

// ===== rtl/core/quaternion_attitude_integrator.sv =====
// Top level: quaternion attitude integrator with stream ports.
// One item at a time. A load gives its result in the cycle after acceptance. An integrate
// passes through the Hamilton product register, the four scaling lanes, the bit-pair
// square root (32 steps and root capture), the shared restoring divider that renormalizes
// each component in turn, the done state and the output register. A zero norm skips the
// root and the divider and returns the held quaternion with zero_norm set.
// A result waits in the output register and the next item is accepted only after it has
// been taken.
`default_nettype none
module quaternion_attitude_integrator
	import qai_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// tdata: rate_x, rate_y, rate_z, time_step, load_w, load_x, load_y, load_z
	input wire logic [127:0] s_tdata,
	// tuser: kind
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// tdata: quat_w, quat_x, quat_y, quat_z
	output logic [63:0] m_tdata,
	// tuser: zero_norm
	output logic m_tuser
);
	localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;
	comp_t q_q [4];
	logic busy_q, lane_go_s1, lane_go_s2;
	logic [15:0] dt_q;
	logic signed [34:0] p [4];
	comp_t s [4];
	comp_t r [4];
	logic ndone, nzero;
	comp_t ox, oy, oz;
	lane_in_t lin [4];
	logic acc;
	assign ox = s_tdata[15:0];
	assign oy = s_tdata[31:16];
	assign oz = s_tdata[47:32];
	assign s_tready = !busy_q && !m_tvalid;
	assign acc = s_tvalid && s_tready;
	always_ff @(posedge clk) begin
		if (acc) begin
			p[0] <= -(35'(ox * q_q[1]) + 35'(oy * q_q[2]) + 35'(oz * q_q[3]));
			p[1] <= 35'(q_q[0] * ox) + (35'(oy * q_q[3]) - 35'(oz * q_q[2]));
			p[2] <= 35'(q_q[0] * oy) + (35'(oz * q_q[1]) - 35'(ox * q_q[3]));
			p[3] <= 35'(q_q[0] * oz) + (35'(ox * q_q[2]) - 35'(oy * q_q[1]));
			dt_q <= s_tdata[63:48];
		end
	end
	for (genvar i = 0; i < 4; i++) begin : g_lane
		assign lin[i] = '{p: p[i], q: q_q[i]};
		qai_lane u_lane (.clk(clk), .start(lane_go_s1), .din(lin[i]), .dt(dt_q), .s(s[i]));
	end
	qai_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
		.clk(clk), .arst_n(arst_n), .start(lane_go_s2),
		.s0(s[0]), .s1(s[1]), .s2(s[2]), .s3(s[3]),
		.done(ndone), .zero(nzero), .r0(r[0]), .r1(r[1]), .r2(r[2]), .r3(r[3])
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q[0] <= sat16(ONE);
			q_q[1] <= '0; q_q[2] <= '0; q_q[3] <= '0;
			busy_q <= 1'b0;
			lane_go_s1 <= 1'b0;
			lane_go_s2 <= 1'b0;
			m_tvalid <= 1'b0;
			m_tuser <= 1'b0;
			m_tdata <= '0;
		end else begin
			lane_go_s1 <= 1'b0;
			lane_go_s2 <= lane_go_s1;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (acc) begin
				if (s_tuser == KIND_LOAD) begin
					q_q[0] <= s_tdata[79:64]; q_q[1] <= s_tdata[95:80];
					q_q[2] <= s_tdata[111:96]; q_q[3] <= s_tdata[127:112];
					m_tdata <= s_tdata[127:64];
					m_tuser <= 1'b0;
					m_tvalid <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					lane_go_s1 <= 1'b1;
				end
			end
			if (ndone) begin
				busy_q <= 1'b0;
				m_tvalid <= 1'b1;
				m_tuser <= nzero;
				if (nzero) m_tdata <= {q_q[3], q_q[2], q_q[1], q_q[0]};
				else begin
					q_q[0] <= r[0]; q_q[1] <= r[1]; q_q[2] <= r[2]; q_q[3] <= r[3];
					m_tdata <= {r[3], r[2], r[1], r[0]};
				end
			end
		end
	end
endmodule
`default_nettype wire
